@@ rtl/core/dfc_pkg.sv @@
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared widths, constants, types and the CORDIC arctangent table for the
// damped fractional comb filter.
// ----------------------------------------------------------------------------
package dfc_pkg;

    localparam int SR_W       = 18;
    localparam int LEN_W      = 17;
    localparam int PITCH_W    = 25;
    localparam int GAIN_W     = 17;
    localparam int DAMP_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b1;

    localparam logic [SR_W-1:0]   SR_RESET  = 18'd48000;
    localparam logic [LEN_W-1:0]  LEN_RESET = 17'd65536;
    localparam logic [LEN_W-1:0]  LEN_MIN   = 17'd4;
    localparam logic [DAMP_W-1:0] DAMP_MAX  = 16'd62259;
    localparam logic [GAIN_W-1:0] DAMP_ONE  = 17'h10000;

    localparam int DEF_LINE_DEPTH  = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int DIV_NW   = 49;
    localparam int DIV_DW   = 42;
    localparam int DIV_CW   = 6;
    localparam int PERIOD_W = 42;
    localparam int W_W      = 32;
    localparam int BACK_W   = 51;

    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 36;
    localparam int ZW           = 33;
    localparam int STEP_W       = 5;
    localparam int PROD_W       = CW + DAMP_W + 1;

    localparam logic [W_W-1:0]       PI_Q30          = 32'd3373259426;
    localparam logic [W_W-1:0]       HALF_PI_Q30     = 32'd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 36'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30         = 36'sd1073741824;

    typedef enum logic {
        CM_ROTATE,
        CM_VECTOR
    } t_cordic_mode;

    typedef struct packed {
        logic         start;
        t_cordic_mode mode;
    } t_cordic_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_W_GO,
        ST_W_WAIT,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_PROJ,
        ST_VEC_GO,
        ST_VEC_WAIT,
        ST_DLY_GO,
        ST_DLY_WAIT,
        ST_ADDR,
        ST_RD_A,
        ST_RD_B,
        ST_INTERP,
        ST_HELD,
        ST_DAMP,
        ST_LP,
        ST_GAINM,
        ST_SUM,
        ST_WRITE
    } t_state;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            default: v = 32'h00000000;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage

@@ rtl/core/damped_fractional_comb_filter.sv @@
// ----------------------------------------------------------------------------
// damped_fractional_comb_filter
// Karplus-Strong feedback comb with fractional delay and one-pole damping.
// ----------------------------------------------------------------------------
// One request is processed at a time. With a non-zero damping pole, up to
// three 49-step divisions (loop period, loop frequency, damper phase delay)
// and two 28-step CORDIC passes dominate a request; with damping zero the
// CORDIC passes and the last division are skipped. The delay line lives in
// a single RAM; when a request arrives after reset or after a change of the
// effective line length, the line is first swept to zero, one entry per
// cycle, over as many entries as the new length, and the request is held
// until the sweep is done. A finished result waits in the output register
// while the next request is accepted.
module damped_fractional_comb_filter
    import dfc_pkg::*;
#(
    parameter int LINE_DEPTH  = DEF_LINE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic [PITCH_W-1:0]            i_pitch,
    input  logic [GAIN_W-1:0]             i_loop_gain,
    input  logic [DAMP_W-1:0]             i_damping,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);

    localparam int SB = SAMPLE_BITS;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_CAP =
        (LINE_DEPTH > 131071) ? 17'h1FFFF : LEN_W'(LINE_DEPTH);
    localparam logic [PERIOD_W-1:0] MIN_PERIOD = PERIOD_W'(131072);
    localparam logic [DIV_NW-1:0] W_NUM = {PI_Q30, 17'b0};
    localparam logic signed [SB+17:0] RND_P = (SB+18)'(32768);
    localparam logic signed [SB+18:0] RND_L = (SB+19)'(32768);
    localparam logic signed [SB+17:0] SMAX = $signed({{19{1'b0}}, {(SB-1){1'b1}}});
    localparam logic signed [SB+17:0] SMIN = $signed({{19{1'b1}}, {(SB-1){1'b0}}});
    localparam logic signed [BACK_W-1:0] BACK_LO = BACK_W'(65536);

    t_state r_state, n_state;

    logic [SR_W-1:0]  r_sample_rate;
    logic [LEN_W-1:0] r_line_length;
    logic [LEN_W-1:0] r_cur_len;
    logic [LEN_W-1:0] r_clr;
    logic [LEN_W-1:0] r_wp;
    logic signed [SB-1:0] r_dm;
    logic                 r_out_valid;
    logic signed [SB-1:0] r_out_data;

    logic signed [SB-1:0]     r_x_in;
    logic [PITCH_W-1:0]       r_pitch;
    logic [GAIN_W-1:0]        r_gain;
    logic [DAMP_W-1:0]        r_damp;
    logic [PERIOD_W-1:0]      r_period;
    logic [W_W-1:0]           r_w;
    logic                     r_fold;
    logic signed [PROD_W-1:0] r_pys;
    logic signed [PROD_W-1:0] r_pxc;
    logic signed [ZW-1:0]     r_z;
    logic [DIV_NW-1:0]        r_delay;
    logic [LEN_W-1:0]         r_whole;
    logic [15:0]              r_frac;
    logic [LEN_W-1:0]         r_ib;
    logic signed [SB-1:0]     r_a;
    logic signed [SB+17:0]    r_prod;
    logic signed [SB-1:0]     r_held;
    logic signed [SB+17:0]    r_m1;
    logic signed [SB+16:0]    r_m2;
    logic signed [SB-1:0]     r_lp;
    logic signed [SB+17:0]    r_gp;
    logic signed [SB-1:0]     r_wr;

    logic [LEN_W-1:0]  len_cap;
    logic [LEN_W-1:0]  len_eff;
    logic [SR_W+3:0]   rate_len;
    logic              len_ok;
    logic              in_fire;
    logic              out_fire;
    logic [PITCH_W-1:0] pmax;
    logic [PITCH_W-1:0] pitch_lim;
    logic [PITCH_W-1:0] pitch_cl;
    logic [DAMP_W-1:0]  damp_cl;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_NW-1:0] div_quo;
    logic              div_done;

    t_cordic_cmd          cor_cmd;
    logic signed [CW-1:0] cor_x0;
    logic signed [CW-1:0] cor_y0;
    logic signed [ZW-1:0] cor_z0;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic signed [ZW-1:0] cor_z;
    logic                 cor_done;
    logic                 fold;
    logic [W_W-1:0]       rot_ang;
    logic signed [CW-1:0] cs;

    logic signed [BACK_W-1:0] back;
    logic signed [BACK_W-1:0] back_hi;
    logic signed [BACK_W-1:0] back_cl;
    logic [LEN_W:0]           ia_sum;
    logic [LEN_W-1:0]         ia;
    logic [LEN_W-1:0]         ib;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [SB-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [SB-1:0]   ram_rdata;
    logic signed [SB-1:0] rd_s;

    logic signed [SB:0]    diff;
    logic signed [SB+17:0] prod_rnd;
    logic signed [SB+17:0] held_w;
    logic signed [SB+18:0] lp_sum;
    logic signed [SB+17:0] gp_rnd;
    logic signed [SB+17:0] wr_full;
    logic signed [SB+17:0] wr_sat;
    logic                  wr_go;

    // effective line length
    always_comb begin
        rate_len = ({4'b0, r_sample_rate} << 3) + ({4'b0, r_sample_rate} << 1);
        len_cap  = (r_line_length > DEPTH_CAP) ? DEPTH_CAP : r_line_length;
        len_eff  = ({5'b0, len_cap} > rate_len) ? rate_len[LEN_W-1:0] : len_cap;
        if (len_eff < LEN_MIN) begin
            len_eff = LEN_MIN;
        end
    end

    assign len_ok   = (r_cur_len == len_eff);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = r_out_valid && i_out_ready;
    assign wr_go    = !r_out_valid || i_out_ready;

    assign pmax      = {r_sample_rate, 7'b0};
    assign pitch_lim = (i_pitch > pmax) ? pmax : i_pitch;
    assign pitch_cl  = (pitch_lim == '0) ? PITCH_W'(1) : pitch_lim;
    assign damp_cl   = (i_damping > DAMP_MAX) ? DAMP_MAX : i_damping;

    assign fold    = (r_w > HALF_PI_Q30);
    assign rot_ang = fold ? (PI_Q30 - r_w) : r_w;
    assign cs      = r_fold ? -cor_x : cor_x;

    assign back    = $signed({1'b0, (BACK_W-1)'(r_period)})
                   - $signed({1'b0, (BACK_W-1)'(r_delay)});
    assign back_hi = $signed(BACK_W'({r_cur_len - LEN_W'(2), 16'b0}));
    assign back_cl = (back < BACK_LO) ? BACK_LO : ((back > back_hi) ? back_hi : back);

    assign ia_sum = {1'b0, r_wp} + {1'b0, r_cur_len} - {1'b0, r_whole};
    assign ia     = (ia_sum >= {1'b0, r_cur_len}) ? LEN_W'(ia_sum - {1'b0, r_cur_len})
                                                  : ia_sum[LEN_W-1:0];
    assign ib     = (ia == '0) ? (r_cur_len - LEN_W'(1)) : (ia - LEN_W'(1));

    assign rd_s     = $signed(ram_rdata);
    assign diff     = $signed({rd_s[SB-1], rd_s}) - $signed({r_a[SB-1], r_a});
    assign prod_rnd = r_prod + RND_P;
    assign held_w   = (SB+18)'(r_a) + (prod_rnd >>> 16);
    assign lp_sum   = (SB+19)'(r_m1) + (SB+19)'(r_m2) + RND_L;
    assign gp_rnd   = r_gp + RND_P;
    assign wr_full  = (gp_rnd >>> 16) + (SB+18)'(r_x_in);
    assign wr_sat   = (wr_full > SMAX) ? SMAX : ((wr_full < SMIN) ? SMIN : wr_full);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!len_ok && i_in_valid) begin
                    n_state = ST_CLEAR;
                end else if (in_fire) begin
                    n_state = ST_PER_GO;
                end
            end
            ST_CLEAR: begin
                if (r_clr == r_cur_len - LEN_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_PER_GO:   n_state = ST_PER_WAIT;
            ST_PER_WAIT: begin
                if (div_done) begin
                    n_state = ST_W_GO;
                end
            end
            ST_W_GO:     n_state = ST_W_WAIT;
            ST_W_WAIT: begin
                if (div_done) begin
                    n_state = (r_damp == '0) ? ST_ADDR : ST_ROT_GO;
                end
            end
            ST_ROT_GO:   n_state = ST_ROT_WAIT;
            ST_ROT_WAIT: begin
                if (cor_done) begin
                    n_state = ST_PROJ;
                end
            end
            ST_PROJ:     n_state = ST_VEC_GO;
            ST_VEC_GO:   n_state = ST_VEC_WAIT;
            ST_VEC_WAIT: begin
                if (cor_done) begin
                    n_state = (cor_z[ZW-1] || cor_z == '0) ? ST_ADDR : ST_DLY_GO;
                end
            end
            ST_DLY_GO:   n_state = ST_DLY_WAIT;
            ST_DLY_WAIT: begin
                if (div_done) begin
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR:     n_state = ST_RD_A;
            ST_RD_A:     n_state = ST_RD_B;
            ST_RD_B:     n_state = ST_INTERP;
            ST_INTERP:   n_state = ST_HELD;
            ST_HELD:     n_state = ST_DAMP;
            ST_DAMP:     n_state = ST_LP;
            ST_LP:       n_state = ST_GAINM;
            ST_GAINM:    n_state = ST_SUM;
            ST_SUM:      n_state = ST_WRITE;
            ST_WRITE: begin
                if (wr_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready   = 1'b0;
        div_start    = 1'b0;
        div_num      = {r_z[30:0], 16'b0, 2'b0} >> 2;
        div_den      = DIV_DW'(r_w);
        cor_cmd      = '{start: 1'b0, mode: CM_ROTATE};
        cor_x0       = CORDIC_GAIN_Q30;
        cor_y0       = '0;
        cor_z0       = $signed({1'b0, rot_ang});
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_wp);
        ram_wdata    = r_wr;
        ram_raddr    = AW'(r_ib);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = len_ok;
            end
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(r_clr);
                ram_wdata = '0;
            end
            ST_PER_GO: begin
                div_start = 1'b1;
                div_num   = DIV_NW'({r_sample_rate, 24'b0});
                div_den   = DIV_DW'(r_pitch);
            end
            ST_W_GO: begin
                div_start = 1'b1;
                div_num   = W_NUM;
                div_den   = DIV_DW'(r_period);
            end
            ST_ROT_GO: begin
                cor_cmd = '{start: 1'b1, mode: CM_ROTATE};
            end
            ST_VEC_GO: begin
                cor_cmd = '{start: 1'b1, mode: CM_VECTOR};
                cor_x0  = ONE_Q30 - CW'(r_pxc >>> 16);
                cor_y0  = CW'(r_pys >>> 16);
                cor_z0  = '0;
            end
            ST_DLY_GO: begin
                div_start = 1'b1;
            end
            ST_RD_A: begin
                ram_raddr = AW'(ia);
            end
            ST_WRITE: begin
                ram_we = wr_go;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_sample_rate <= SR_RESET;
            r_line_length <= LEN_RESET;
            r_cur_len     <= '0;
            r_clr         <= '0;
            r_wp          <= '0;
            r_dm          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[SR_W-1:0];
                    CFG_LINE_LENGTH: r_line_length <= i_cfg_data[LEN_W-1:0];
                    default:         r_line_length <= r_line_length;
                endcase
            end
            if (r_state == ST_IDLE && !len_ok && i_in_valid) begin
                r_cur_len <= len_eff;
                r_clr     <= '0;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + LEN_W'(1);
                r_wp  <= '0;
                r_dm  <= '0;
            end
            if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_WRITE && wr_go) begin
                r_out_valid <= 1'b1;
                r_dm        <= r_lp;
                r_wp        <= (r_wp == r_cur_len - LEN_W'(1)) ? '0 : r_wp + LEN_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x_in  <= i_sample_in;
            r_pitch <= pitch_cl;
            r_gain  <= i_loop_gain;
            r_damp  <= damp_cl;
        end
        case (r_state)
            ST_PER_WAIT: begin
                if (div_done) begin
                    r_period <= (div_quo[PERIOD_W-1:0] < MIN_PERIOD) ? MIN_PERIOD
                                                                    : div_quo[PERIOD_W-1:0];
                end
            end
            ST_W_WAIT: begin
                if (div_done) begin
                    r_w     <= div_quo[W_W-1:0];
                    r_delay <= '0;
                end
            end
            ST_ROT_GO: begin
                r_fold <= fold;
            end
            ST_PROJ: begin
                r_pys <= $signed({1'b0, r_damp}) * cor_y;
                r_pxc <= $signed({1'b0, r_damp}) * cs;
            end
            ST_VEC_WAIT: begin
                if (cor_done) begin
                    r_z <= cor_z;
                end
            end
            ST_DLY_WAIT: begin
                if (div_done) begin
                    r_delay <= div_quo;
                end
            end
            ST_ADDR: begin
                r_whole <= back_cl[LEN_W+15:16];
                r_frac  <= back_cl[15:0];
            end
            ST_RD_A: begin
                r_ib <= ib;
            end
            ST_RD_B: begin
                r_a <= rd_s;
            end
            ST_INTERP: begin
                r_prod <= diff * $signed({1'b0, r_frac});
            end
            ST_HELD: begin
                r_held <= held_w[SB-1:0];
            end
            ST_DAMP: begin
                r_m1 <= $signed({1'b0, DAMP_ONE - {1'b0, r_damp}}) * r_held;
                r_m2 <= $signed({1'b0, r_damp}) * r_dm;
            end
            ST_LP: begin
                r_lp <= lp_sum[SB+15:16];
            end
            ST_GAINM: begin
                r_gp <= $signed({1'b0, r_gain}) * r_lp;
            end
            ST_SUM: begin
                r_wr <= wr_sat[SB-1:0];
            end
            ST_WRITE: begin
                if (wr_go) begin
                    r_out_data <= r_wr;
                end
            end
            default: begin
                r_frac <= r_frac;
            end
        endcase
    end

    dfc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    dfc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cor_cmd),
        .i_x     (cor_x0),
        .i_y     (cor_y0),
        .i_z     (cor_z0),
        .o_x     (cor_x),
        .o_y     (cor_y),
        .o_z     (cor_z),
        .o_done  (cor_done)
    );

    dfc_ram #(
        .WIDTH (SB),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

`ifndef SYNTHESIS
    a_wp_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && len_ok) |-> (r_wp < r_cur_len))
        else $error("write pointer outside line");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_A) |-> (r_whole >= LEN_W'(1) && r_whole <= r_cur_len - LEN_W'(2)))
        else $error("tap distance outside line");

    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_WRITE))
        else $error("result raised outside write step");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_PER_GO))
        else $error("accepted request not started");
`endif

endmodule

@@ rtl/core/dfc_ram.sv @@
// ----------------------------------------------------------------------------
// dfc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/dfc_divider.sv @@
// ----------------------------------------------------------------------------
// dfc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dfc_divider
    import dfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_done
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_DW:0]   trial;
    logic              qbit;

    assign trial = {r_rem, r_num[DIV_NW-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CW'(1);
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? DIV_DW'(trial - {1'b0, r_den}) : trial[DIV_DW-1:0];
            r_num <= {r_num[DIV_NW-2:0], qbit};
        end
    end

    assign o_quo  = r_num;
    assign o_done = r_done;

endmodule

@@ rtl/core/dfc_cordic.sv @@
// ----------------------------------------------------------------------------
// dfc_cordic
// Iterative CORDIC, rotation or vectoring mode, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module dfc_cordic
    import dfc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_cmd          i_cmd,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic                 o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_i;
    t_cordic_mode         r_mode;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] ang;
    logic                 neg;

    assign sx  = r_x >>> r_i;
    assign sy  = r_y >>> r_i;
    assign ang = atan_q30(r_i);
    assign neg = (r_mode == CM_ROTATE) ? r_z[ZW-1] : !r_y[CW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
            r_mode <= CM_ROTATE;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_mode <= i_cmd.mode;
            end else if (r_busy) begin
                r_i <= r_i + STEP_W'(1);
                if (r_i == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (r_busy) begin
            if (neg) begin
                r_x <= r_x + sy;
                r_y <= r_y - sx;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - sy;
                r_y <= r_y + sx;
                r_z <= r_z - ang;
            end
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_done = r_done;

endmodule
